>>> sv/lod_select_hysteresis_defines.svh
// Assertion macros shared by the checkers of the LOD selection block.
`ifndef LOD_SELECT_HYSTERESIS_DEFINES_SVH
`define LOD_SELECT_HYSTERESIS_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define LSH_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("LOD selection check failed in the same cycle");

// Consequent checked in the cycle after the antecedent.
`define LSH_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("LOD selection check failed one cycle later");

`endif

>>> sv/lsh_pkg.sv
// Types, constants and the microcode table of the LOD selection block.
`default_nettype none

package lsh_pkg;

   localparam int LEVELS     = 4;
   localparam int CNT_W      = 3;
   localparam int LVL_W      = 2;
   localparam int POS_W      = 16;
   localparam int DIFF_W     = POS_W + 1;
   localparam int BIAS_W     = 16;
   localparam int LIM_W      = 36;
   localparam int HALF_W     = 18;
   localparam int MUL_B_W    = 16;
   localparam int PROD_W     = HALF_W + MUL_B_W;
   localparam int ACC_W      = PROD_W + HALF_W;
   localparam int DIST_W     = 34;
   localparam int STEP_W     = 4;
   localparam int REQ_DATA_W = 7 * POS_W;
   localparam int RSP_DATA_W = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int BIAS_SHIFT = 12;
   localparam int TOL_SHIFT  = 10;

   localparam logic [LIM_W-1:0]   LIMIT_MAX = {LIM_W{1'b1}};
   localparam logic [MUL_B_W-1:0] TOL_NUM   = 16'd1045;
   localparam logic [STEP_W-1:0]  LOOP_STEP = 4'd4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LEVEL_COUNT = 3'd0,
      CSR_LIMIT0      = 3'd1,
      CSR_LIMIT1      = 3'd2,
      CSR_LIMIT2      = 3'd3,
      CSR_LIMIT3      = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      A_DX, A_DY, A_DZ, A_LIM_LO, A_LIM_HI, A_THR_LO, A_THR_HI
   } a_sel_type;

   typedef enum logic [2:0] {
      B_DX, B_DY, B_DZ, B_BIAS, B_TOL
   } b_sel_type;

   typedef enum logic [2:0] {
      ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_ADD_HI, ACC_DIST, ACC_SAT_BIAS, ACC_SAT_TOL
   } acc_op_type;

   typedef enum logic [2:0] {
      BR_NEXT, BR_XFORM, BR_LEVEL, BR_HYST, BR_CMP
   } branch_type;

   typedef struct packed {
      a_sel_type  a_sel;
      b_sel_type  b_sel;
      acc_op_type acc_op;
      branch_type branch;
   } ucode_type;

   // The multiplier result is registered, so each step consumes the product issued
   // by the step before it while issuing the next one.
   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type w;
      case (step)
         4'd0:    w = '{A_DX,     B_DX,   ACC_HOLD,     BR_XFORM};
         4'd1:    w = '{A_DY,     B_DY,   ACC_LOAD,     BR_NEXT};
         4'd2:    w = '{A_DZ,     B_DZ,   ACC_ADD,      BR_NEXT};
         4'd3:    w = '{A_DX,     B_DX,   ACC_DIST,     BR_NEXT};
         4'd4:    w = '{A_LIM_LO, B_BIAS, ACC_HOLD,     BR_LEVEL};
         4'd5:    w = '{A_LIM_HI, B_BIAS, ACC_LOAD,     BR_NEXT};
         4'd6:    w = '{A_DX,     B_DX,   ACC_ADD_HI,   BR_NEXT};
         4'd7:    w = '{A_DX,     B_DX,   ACC_SAT_BIAS, BR_NEXT};
         4'd8:    w = '{A_THR_LO, B_TOL,  ACC_HOLD,     BR_HYST};
         4'd9:    w = '{A_THR_HI, B_TOL,  ACC_LOAD,     BR_NEXT};
         4'd10:   w = '{A_DX,     B_DX,   ACC_ADD_HI,   BR_NEXT};
         4'd11:   w = '{A_DX,     B_DX,   ACC_SAT_TOL,  BR_NEXT};
         4'd12:   w = '{A_DX,     B_DX,   ACC_HOLD,     BR_CMP};
         default: w = '{A_DX,     B_DX,   ACC_HOLD,     BR_NEXT};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

>>> sv/lod_select_hysteresis.sv
// Distance-based level-of-detail selection with hysteresis, microcoded top level.
//
// Input words arrive on the req_ stream: camera and object positions (signed Q12.4)
// and the bias (Q4.12) in req_tdata, the has-transform flag in req_tuser. Each word
// gives exactly one result word on the rsp_ stream: the level in rsp_tdata and the
// visible flag in rsp_tuser. Levels and squared limits are written on the csr_ port,
// which is always ready and must only be used while the block is idle.
// One item is in work at a time. A step counter walks a 13-entry microcode table
// that drives a single registered 18x16 multiplier and a 52-bit accumulator.
// Without a transform the item finishes at the first step. Otherwise the steps form
// the squared distance, then for each level examined the biased limit, for the
// remembered level also scaled by the tolerance, and a compare; a never-culled level
// accepts at once, and a culled result follows when no level accepts.
// A finished result waits in the output register; a new word is accepted as soon as
// the previous item has finished, even while its result is still stalled. A stall
// of the receiver only holds the sequencer once a second result is ready.
// Reset clears the remembered level, sets the level count to zero and every limit to
// the never-culled value, and empties the output register.
`default_nettype none

module lod_select_hysteresis (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // cam_x, cam_y, cam_z, obj_x, obj_y, obj_z, lod_bias
   input  logic [lsh_pkg::REQ_DATA_W-1:0]  req_tdata,
   // has_transform
   input  logic [0:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // level, then zero padding
   output logic [lsh_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // visible
   output logic [0:0]                      rsp_tuser,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [lsh_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lsh_pkg::LIM_W-1:0]       csr_data
);
   import lsh_pkg::*;

   logic [POS_W-1:0]  cam_x_ff, cam_y_ff, cam_z_ff, obj_x_ff, obj_y_ff, obj_z_ff;
   logic [POS_W-1:0]  cam_x_in, cam_y_in, cam_z_in, obj_x_in, obj_y_in, obj_z_in;
   logic [BIAS_W-1:0] bias_ff, bias_in;
   logic              xform_ff, xform_in;
   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  lvl_ff, lvl_in;
   logic [LVL_W-1:0]  last_ff, last_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [DIST_W-1:0] dist_ff, dist_in;
   logic [LIM_W-1:0]  thr_ff, thr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [LVL_W-1:0]  rsp_level_ff, rsp_level_in;
   logic              rsp_vis_ff, rsp_vis_in;
   logic [CNT_W-1:0]  level_count_ff, level_count_in;
   logic [LIM_W-1:0]  limit_ff [LEVELS];
   logic [LIM_W-1:0]  limit_in [LEVELS];

   ucode_type           uc;
   logic                req_accept, out_free, advance;
   logic                finish, fin_vis, fin_remember;
   logic [LVL_W-1:0]    fin_level;
   logic [STEP_W-1:0]   next_step;
   logic [CNT_W-1:0]    count_eff;
   logic [LIM_W-1:0]    lim_sel;
   logic                dist_below;
   logic [POS_W-1:0]    mag_x, mag_y, mag_z;
   logic [HALF_W-1:0]   mul_a;
   logic [MUL_B_W-1:0]  mul_b;

   function automatic logic [POS_W-1:0] abs_diff(input logic [POS_W-1:0] a,
                                                 input logic [POS_W-1:0] b);
      logic signed [DIFF_W-1:0] d;
      logic        [DIFF_W-1:0] n;
      d = $signed({a[POS_W-1], a}) - $signed({b[POS_W-1], b});
      n = DIFF_W'(-d);
      return d[DIFF_W-1] ? n[POS_W-1:0] : d[POS_W-1:0];
   endfunction

   function automatic logic [LIM_W-1:0] sat_limit(input logic [ACC_W-1:0] v);
      return (|v[ACC_W-1:LIM_W]) ? LIMIT_MAX : v[LIM_W-1:0];
   endfunction

   assign uc         = ucode_rom(step_ff);
   assign req_tready = !busy_ff;
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = busy_ff && !(finish && !out_free);
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_level_ff);
   assign rsp_tuser  = rsp_vis_ff;

   assign mag_x      = abs_diff(cam_x_ff, obj_x_ff);
   assign mag_y      = abs_diff(cam_y_ff, obj_y_ff);
   assign mag_z      = abs_diff(cam_z_ff, obj_z_ff);
   assign lim_sel    = limit_ff[lvl_ff[LVL_W-1:0]];
   assign count_eff  = (level_count_ff > CNT_W'(LEVELS)) ? CNT_W'(LEVELS) : level_count_ff;
   assign dist_below = LIM_W'(dist_ff) < thr_ff;

   // Operand selection for the shared multiplier.
   always_comb begin
      case (uc.a_sel)
         A_DX:     mul_a = HALF_W'(mag_x);
         A_DY:     mul_a = HALF_W'(mag_y);
         A_DZ:     mul_a = HALF_W'(mag_z);
         A_LIM_LO: mul_a = lim_sel[HALF_W-1:0];
         A_LIM_HI: mul_a = lim_sel[LIM_W-1:HALF_W];
         A_THR_LO: mul_a = thr_ff[HALF_W-1:0];
         A_THR_HI: mul_a = thr_ff[LIM_W-1:HALF_W];
         default:  mul_a = '0;
      endcase
      case (uc.b_sel)
         B_DX:    mul_b = mag_x;
         B_DY:    mul_b = mag_y;
         B_DZ:    mul_b = mag_z;
         B_BIAS:  mul_b = bias_ff;
         B_TOL:   mul_b = TOL_NUM;
         default: mul_b = '0;
      endcase
      prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   // Branch decode: decides whether the item finishes in this step and where to go.
   always_comb begin
      finish       = 1'b0;
      fin_vis      = 1'b1;
      fin_remember = 1'b0;
      fin_level    = lvl_ff[LVL_W-1:0];
      next_step    = step_ff + STEP_W'(1);
      lvl_in       = lvl_ff;
      unique case (uc.branch) inside
         BR_NEXT: ;
         BR_XFORM: begin
            if (!xform_ff) begin
               finish    = 1'b1;
               fin_level = '0;
            end
         end
         BR_LEVEL: begin
            if (lvl_ff >= count_eff) begin
               finish    = 1'b1;
               fin_vis   = 1'b0;
               fin_level = '0;
            end else if (lim_sel == LIMIT_MAX) begin
               finish       = 1'b1;
               fin_remember = 1'b1;
            end
         end
         BR_HYST, BR_CMP: begin
            // The remembered level falls through to the tolerance steps.
            if (uc.branch == BR_CMP || lvl_ff[LVL_W-1:0] != last_ff) begin
               if (dist_below) begin
                  finish       = 1'b1;
                  fin_remember = 1'b1;
               end else begin
                  lvl_in    = lvl_ff + CNT_W'(1);
                  next_step = LOOP_STEP;
               end
            end
         end
         default: ;
      endcase
   end

   // Next values of the item, sequencer, datapath and result registers.
   always_comb begin
      cam_x_in     = cam_x_ff;
      cam_y_in     = cam_y_ff;
      cam_z_in     = cam_z_ff;
      obj_x_in     = obj_x_ff;
      obj_y_in     = obj_y_ff;
      obj_z_in     = obj_z_ff;
      bias_in      = bias_ff;
      xform_in     = xform_ff;
      busy_in      = busy_ff;
      step_in      = step_ff;
      last_in      = last_ff;
      acc_in       = acc_ff;
      dist_in      = dist_ff;
      thr_in       = thr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_level_in = rsp_level_ff;
      rsp_vis_in   = rsp_vis_ff;

      if (req_accept) begin
         cam_x_in = req_tdata[0*POS_W +: POS_W];
         cam_y_in = req_tdata[1*POS_W +: POS_W];
         cam_z_in = req_tdata[2*POS_W +: POS_W];
         obj_x_in = req_tdata[3*POS_W +: POS_W];
         obj_y_in = req_tdata[4*POS_W +: POS_W];
         obj_z_in = req_tdata[5*POS_W +: POS_W];
         bias_in  = req_tdata[6*POS_W +: BIAS_W];
         xform_in = req_tuser[0];
         busy_in  = 1'b1;
         step_in  = '0;
      end else if (advance) begin
         step_in = next_step;
         case (uc.acc_op)
            ACC_LOAD:     acc_in  = ACC_W'(prod_ff);
            ACC_ADD:      acc_in  = acc_ff + ACC_W'(prod_ff);
            ACC_ADD_HI:   acc_in  = acc_ff + {prod_ff, {HALF_W{1'b0}}};
            ACC_DIST:     dist_in = DIST_W'(acc_ff + ACC_W'(prod_ff));
            ACC_SAT_BIAS: thr_in  = sat_limit(acc_ff >> BIAS_SHIFT);
            ACC_SAT_TOL:  thr_in  = sat_limit(acc_ff >> TOL_SHIFT);
            default: ;
         endcase
         if (finish) begin
            busy_in      = 1'b0;
            rsp_valid_in = 1'b1;
            rsp_level_in = fin_level;
            rsp_vis_in   = fin_vis;
            if (fin_remember) begin
               last_in = fin_level;
            end
         end
      end
   end

   // Register writes.
   always_comb begin
      level_count_in = level_count_ff;
      for (int i = 0; i < LEVELS; i++) begin
         limit_in[i] = limit_ff[i];
      end
      if (csr_valid && csr_ready) begin
         unique case (csr_index) inside
            CSR_LEVEL_COUNT: level_count_in = csr_data[CNT_W-1:0];
            CSR_LIMIT0, CSR_LIMIT1, CSR_LIMIT2, CSR_LIMIT3: begin
               limit_in[LVL_W'(csr_index - CSR_IDX_W'(CSR_LIMIT0))] = csr_data;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b0;
         step_ff        <= '0;
         lvl_ff         <= '0;
         last_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
         level_count_ff <= '0;
         for (int i = 0; i < LEVELS; i++) begin
            limit_ff[i] <= LIMIT_MAX;
         end
      end else begin
         busy_ff        <= busy_in;
         step_ff        <= step_in;
         lvl_ff         <= req_accept ? '0 : (advance ? lvl_in : lvl_ff);
         last_ff        <= last_in;
         rsp_valid_ff   <= rsp_valid_in;
         level_count_ff <= level_count_in;
         for (int i = 0; i < LEVELS; i++) begin
            limit_ff[i] <= limit_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      cam_x_ff     <= cam_x_in;
      cam_y_ff     <= cam_y_in;
      cam_z_ff     <= cam_z_in;
      obj_x_ff     <= obj_x_in;
      obj_y_ff     <= obj_y_in;
      obj_z_ff     <= obj_z_in;
      bias_ff      <= bias_in;
      xform_ff     <= xform_in;
      prod_ff      <= advance ? prod_in : prod_ff;
      acc_ff       <= acc_in;
      dist_ff      <= dist_in;
      thr_ff       <= thr_in;
      rsp_level_ff <= rsp_level_in;
      rsp_vis_ff   <= rsp_vis_in;
   end

endmodule

`default_nettype wire

>>> sv/lsh_checker.sv
// Port-level checker for the LOD selection block and its bind statement.
`default_nettype none
`include "lod_select_hysteresis_defines.svh"

module lsh_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [lsh_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic [0:0]                      rsp_tuser
);
   import lsh_pkg::*;

   // A word that waits for the receiver keeps its contents.
   `LSH_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `LSH_ASSERT_NEXT(a_rsp_user_hold, rsp_tvalid && !rsp_tready, $stable(rsp_tuser))

   // Only one item is in work: an accepted word closes the input.
   `LSH_ASSERT_NEXT(a_one_item, req_tvalid && req_tready, !req_tready)

   // A culled object always reports level zero.
   `LSH_ASSERT_NOW(a_culled_level, rsp_tvalid && !rsp_tuser[0], rsp_tdata[LVL_W-1:0] == '0)

endmodule

bind lod_select_hysteresis lsh_checker u_lsh_checker (.*);

`default_nettype wire

>>> tb/lod_select_hysteresis_tb.sv
// Self-checking testbench for the LOD selection block, with a directed table and random words.
`timescale 1ns / 100ps

module lod_select_hysteresis_tb;
   import lsh_pkg::*;

   localparam int CLOCK_HALF   = 6;
   localparam int RESET_CYCLES = 6;
   localparam int PHASES       = 8;
   localparam int PHASE_WORDS  = 175;
   localparam int HOLD_PHASE   = 3;
   localparam int PAUSE_PHASE  = 5;
   localparam int MAX_IDLE     = 19;
   localparam int LONG_HOLD    = 400;
   localparam int TAIL_CYCLES  = 40;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int ONE_BIAS     = 4096;

   localparam int POS_MIN  = -32768;
   localparam int POS_MAX  = 32767;
   localparam int BIAS_MAX = 65535;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_LO = 3'(CSR_LIMIT3 + 1);
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_HI = '1;

   typedef struct packed {
      logic [POS_W-1:0]  cam_x, cam_y, cam_z;
      logic [POS_W-1:0]  obj_x, obj_y, obj_z;
      logic [BIAS_W-1:0] lod_bias;
      logic              has_transform;
   } lod_query_type;

   typedef struct packed {
      logic [LVL_W-1:0] level;
      logic             visible;
   } lod_result_type;

   typedef enum logic {ROW_CSR, ROW_QUERY} row_kind_type;

   typedef struct {
      row_kind_type         kind;
      logic [CSR_IDX_W-1:0] csr_idx;
      logic [LIM_W-1:0]     csr_val;
      lod_query_type        query;
      bit                   typed;
      lod_result_type       want;
   } stim_row_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // cam_x, cam_y, cam_z, obj_x, obj_y, obj_z, lod_bias
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   // has_transform
   logic [0:0]             req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // level, then zero padding
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   // visible
   logic [0:0]             rsp_tuser;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index  = '0;
   logic [LIM_W-1:0]       csr_data   = '0;

   // Local copy of the block's registers and of the remembered level.
   logic [CNT_W-1:0]       level_count_q;
   logic [LIM_W-1:0]       limit_sq_q [LEVELS];
   logic [LVL_W-1:0]       held_level;

   lod_result_type         chosen_levels [$];
   stim_row_type           directed_rows [$];
   int                     mismatches    = 0;
   int                     cycle_count   = 0;
   int                     rx_hold_cycles = 0;
   bit                     tx_no_gaps    = 1'b0;
   bit                     rx_no_stalls  = 1'b0;

   lod_select_hysteresis u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #(CLOCK_HALF) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic logic [LIM_W-1:0] axis_square(input logic [POS_W-1:0] a,
                                                     input logic [POS_W-1:0] b);
      logic signed [DIFF_W-1:0] d;
      logic [DIFF_W-1:0]        m;
      d = {a[POS_W-1], a} - {b[POS_W-1], b};
      m = d[DIFF_W-1] ? -d : d;
      return LIM_W'(m) * LIM_W'(m);
   endfunction

   function automatic logic [LIM_W-1:0] clamp_limit(input logic [63:0] v);
      return (v > 64'(LIMIT_MAX)) ? LIMIT_MAX : v[LIM_W-1:0];
   endfunction

   // Works out the result of one query and moves the remembered level on a hit.
   function automatic lod_result_type select_level(input lod_query_type q);
      lod_result_type   r;
      logic [LIM_W-1:0] sq_sum;
      logic [LIM_W-1:0] thr;
      int               n;
      bit               hit;
      bit               accept;
      r = '0;
      if (!q.has_transform) begin
         r.visible = 1'b1;
         return r;
      end
      sq_sum = axis_square(q.cam_x, q.obj_x) + axis_square(q.cam_y, q.obj_y)
             + axis_square(q.cam_z, q.obj_z);
      n = (level_count_q > LEVELS) ? LEVELS : int'(level_count_q);
      hit = 1'b0;
      for (int i = 0; i < n; i++) begin
         if (!hit) begin
            if (limit_sq_q[i] == LIMIT_MAX) begin
               accept = 1'b1;
            end else begin
               thr = clamp_limit((64'(limit_sq_q[i]) * 64'(q.lod_bias)) >> BIAS_SHIFT);
               if (i == int'(held_level))
                  thr = clamp_limit((64'(thr) * 64'(TOL_NUM)) >> TOL_SHIFT);
               accept = sq_sum < thr;
            end
            if (accept) begin
               held_level = LVL_W'(i);
               r.level    = LVL_W'(i);
               r.visible  = 1'b1;
               hit        = 1'b1;
            end
         end
      end
      return r;
   endfunction

   function automatic lod_query_type query_of(input int cx, cy, cz,
                                              input int ox, oy, oz,
                                              input int bias,
                                              input bit xform);
      lod_query_type q;
      q = '{POS_W'(cx), POS_W'(cy), POS_W'(cz), POS_W'(ox), POS_W'(oy), POS_W'(oz),
            BIAS_W'(bias), xform};
      return q;
   endfunction

   task automatic add_write(input logic [CSR_IDX_W-1:0] idx, input logic [LIM_W-1:0] val);
      stim_row_type row;
      row = '{ROW_CSR, idx, val, '0, 1'b0, '0};
      directed_rows = {directed_rows, row};
   endtask

   task automatic add_query(input lod_query_type q);
      stim_row_type row;
      row = '{ROW_QUERY, '0, '0, q, 1'b0, '0};
      directed_rows = {directed_rows, row};
   endtask

   task automatic add_known(input lod_query_type q, input int lvl, input int vis);
      stim_row_type row;
      row = '{ROW_QUERY, '0, '0, q, 1'b1, '{LVL_W'(lvl), 1'(vis)}};
      directed_rows = {directed_rows, row};
   endtask

   // Offers one word after a random gap (none when gaps are off) and files its expected result on acceptance.
   task automatic send_query(input lod_query_type q, input bit typed,
                             input lod_result_type want);
      int             gap;
      lod_result_type r;
      gap = tx_no_gaps ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {q.lod_bias, q.obj_z, q.obj_y, q.obj_x, q.cam_z, q.cam_y, q.cam_x};
      req_tuser  <= q.has_transform;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      r = select_level(q);
      chosen_levels = {chosen_levels, (typed ? want : r)};
   endtask

   // Leaves csr_valid high; the caller lowers it once the batch of writes is done.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [LIM_W-1:0] val);
      csr_index <= idx;
      csr_data  <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (idx) inside
         CSR_LEVEL_COUNT: level_count_q = val[CNT_W-1:0];
         CSR_LIMIT0, CSR_LIMIT1, CSR_LIMIT2, CSR_LIMIT3:
            limit_sq_q[LVL_W'(idx - CSR_LIMIT0)] = val;
         default: ;
      endcase
   endtask

   task automatic quiesce();
      req_tvalid <= 1'b0;
      while (chosen_levels.size() != 0) @(posedge clock);
   endtask

   initial begin : result_sink
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = rx_no_stalls ? 0 : $urandom_range(0, MAX_IDLE);
         stall += rx_hold_cycles;
         rx_hold_cycles = 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   always @(posedge clock) begin : result_check
      lod_result_type got;
      lod_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.level   = rsp_tdata[LVL_W-1:0];
         got.visible = rsp_tuser[0];
         if (chosen_levels.size() == 0) begin
            $error("result word with nothing pending: level %0d visible %0d",
                   got.level, got.visible);
            mismatches++;
         end else begin
            want = chosen_levels.pop_front();
            if (got.visible !== want.visible) begin
               $error("visible: expected %0d, got %0d", want.visible, got.visible);
               mismatches++;
            end
            if (got.level !== want.level) begin
               $error("level: expected %0d, got %0d", want.level, got.level);
               mismatches++;
            end
         end
      end
   end

   initial begin : stimulus
      lod_query_type    q;
      lod_query_type    prev_q;
      bit               have_prev;
      bit               csr_active;
      int               span;
      int               spread;
      int               radius;
      int               kind;
      logic [CNT_W-1:0] count;
      logic [LIM_W-1:0] val;

      level_count_q = '0;
      foreach (limit_sq_q[i]) limit_sq_q[i] = LIMIT_MAX;
      held_level = '0;

      // Straight after reset no level is in use, so only untransformed objects show.
      add_known(query_of(POS_MAX, POS_MAX, POS_MAX, POS_MIN, POS_MIN, POS_MIN, 0, 1'b0), 0, 1);
      add_known(query_of(0, 0, 0, 0, 0, 0, ONE_BIAS, 1'b1), 0, 0);
      add_write(CSR_LIMIT0, LIM_W'(40000));
      add_write(CSR_LIMIT1, LIM_W'(160000));
      add_write(CSR_LIMIT2, LIMIT_MAX - LIM_W'(1));
      add_write(CSR_LIMIT3, LIMIT_MAX);
      add_write(CSR_LEVEL_COUNT, LIM_W'(4));
      // Walk out across the level 0 boundary and back, through the tolerance band.
      add_query(query_of(0, 0, 0, 199, 0, 0, ONE_BIAS, 1'b1));
      add_query(query_of(0, 0, 0, 202, 0, 0, ONE_BIAS, 1'b1));
      add_query(query_of(0, 0, 0, 205, 0, 0, ONE_BIAS, 1'b1));
      add_query(query_of(0, 0, 0, 202, 0, 0, ONE_BIAS, 1'b1));
      add_query(query_of(0, 0, 0, 199, 0, 0, ONE_BIAS, 1'b1));
      // Largest distance; the full bias saturates the near-maximum limit.
      add_query(query_of(POS_MIN, POS_MIN, POS_MIN, POS_MAX, POS_MAX, POS_MAX, BIAS_MAX, 1'b1));
      // With a zero bias only the never-culled level can accept.
      add_known(query_of(POS_MIN, POS_MIN, POS_MIN, POS_MAX, POS_MAX, POS_MAX, 0, 1'b1), 3, 1);
      add_known(query_of(0, 0, 0, 0, 0, 0, 0, 1'b1), 3, 1);
      add_query(query_of(1234, -555, 77, 1234, -555, 77, ONE_BIAS, 1'b1));
      add_query(query_of(POS_MAX, POS_MIN, 0, POS_MIN, POS_MAX, 100, BIAS_MAX, 1'b1));
      add_write(CSR_LIMIT3, LIM_W'(0));
      add_write(CSR_LIMIT2, LIM_W'(1000));
      add_write(CSR_LEVEL_COUNT, LIM_W'(7));
      add_known(query_of(POS_MIN, POS_MIN, POS_MIN, POS_MAX, POS_MAX, POS_MAX, ONE_BIAS, 1'b1),
                0, 0);
      add_known(query_of(POS_MIN, POS_MIN, POS_MIN, POS_MAX, POS_MAX, POS_MAX, ONE_BIAS, 1'b0),
                0, 1);
      add_query(query_of(0, 0, 0, 300, 0, 0, ONE_BIAS, 1'b1));
      add_write(CSR_LEVEL_COUNT, LIM_W'(0));
      add_known(query_of(0, 0, 0, 0, 0, 0, ONE_BIAS, 1'b1), 0, 0);
      add_write(CSR_LEVEL_COUNT, LIM_W'(2));
      add_known(query_of(POS_MIN, POS_MIN, POS_MIN, POS_MAX, POS_MAX, POS_MAX, ONE_BIAS, 1'b1),
                0, 0);
      // Writes past the last register must leave everything as it was.
      for (int j = CSR_UNMAPPED_LO; j <= CSR_UNMAPPED_HI; j++)
         add_write(CSR_IDX_W'(j), LIM_W'({$urandom, $urandom}));
      add_query(query_of(0, 0, 0, 199, 0, 0, ONE_BIAS, 1'b1));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      csr_active = 1'b0;
      foreach (directed_rows[k]) begin
         if (directed_rows[k].kind == ROW_CSR) begin
            if (!csr_active) quiesce();
            write_csr(directed_rows[k].csr_idx, directed_rows[k].csr_val);
            csr_active = 1'b1;
         end else begin
            if (csr_active) csr_valid <= 1'b0;
            csr_active = 1'b0;
            send_query(directed_rows[k].query, directed_rows[k].typed, directed_rows[k].want);
         end
      end

      have_prev = 1'b0;
      prev_q    = '0;
      for (int phase = 0; phase < PHASES; phase++) begin
         quiesce();
         // Roughly ascending radii put the levels where the distances actually fall.
         radius = $urandom_range(0, 8000);
         for (int i = 0; i < LEVELS; i++) begin
            if (i > 0) radius += $urandom_range(0, 30000);
            kind = $urandom_range(0, 15);
            case (kind)
               0, 1:    val = LIMIT_MAX;
               2:       val = '0;
               3:       val = LIMIT_MAX - LIM_W'(1);
               4, 5:    val = LIM_W'({$urandom, $urandom});
               default: val = LIM_W'(longint'(radius) * radius);
            endcase
            write_csr(CSR_IDX_W'(CSR_LIMIT0 + i), val);
         end
         if (phase == 0)
            count = CNT_W'(LEVELS);
         else if (phase == PHASES - 1)
            count = '1;
         else
            count = ($urandom_range(0, 3) == 0) ? CNT_W'($urandom_range(0, 7)) : CNT_W'(LEVELS);
         val = LIM_W'({$urandom, $urandom});
         val[CNT_W-1:0] = count;
         write_csr(CSR_LEVEL_COUNT, val);
         csr_valid <= 1'b0;

         tx_no_gaps   = (phase % 3 == 1) || (phase == HOLD_PHASE);
         rx_no_stalls = (phase % 3 == 2);
         // The receiver sits out a long stretch while words keep coming.
         if (phase == HOLD_PHASE) rx_hold_cycles = LONG_HOLD;

         for (int n = 0; n < PHASE_WORDS; n++) begin
            if (phase == PAUSE_PHASE && n == PHASE_WORDS / 2) quiesce();
            if (have_prev && $urandom_range(0, 2) == 0) begin
               // Nudge the last object so that the distance hovers near a boundary.
               q = prev_q;
               q.obj_x = q.obj_x + POS_W'($urandom_range(0, 32) - 16);
               q.obj_y = q.obj_y + POS_W'($urandom_range(0, 8) - 4);
            end else begin
               q.cam_x = POS_W'($urandom);
               q.cam_y = POS_W'($urandom);
               q.cam_z = POS_W'($urandom);
               spread = $urandom_range(0, 3);
               span = (spread == 0) ? 64 : (spread == 1) ? 4096 : 32767;
               if (spread == 3) begin
                  q.obj_x = POS_W'($urandom);
                  q.obj_y = POS_W'($urandom);
                  q.obj_z = POS_W'($urandom);
               end else begin
                  q.obj_x = q.cam_x + POS_W'($urandom_range(0, 2 * span) - span);
                  q.obj_y = q.cam_y + POS_W'($urandom_range(0, 2 * span) - span);
                  q.obj_z = q.cam_z + POS_W'($urandom_range(0, 2 * span) - span);
               end
               case ($urandom_range(0, 9))
                  0:       q.lod_bias = '0;
                  1:       q.lod_bias = BIAS_W'(BIAS_MAX);
                  2:       q.lod_bias = BIAS_W'($urandom);
                  default: q.lod_bias = BIAS_W'($urandom_range(3072, 5120));
               endcase
               q.has_transform = ($urandom_range(0, 9) != 0);
            end
            send_query(q, 1'b0, '0);
            prev_q    = q;
            have_prev = 1'b1;
         end
      end

      quiesce();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
